>>> hw/rtl/tccs_pkg.sv
package tccs_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = ROWS * COLUMNS;
  localparam int COPY_CELLS = CELLS - COLUMNS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int BYTE_W = 8;
  localparam int CELL_W = 16;

  localparam int CELL_AW = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);

  localparam logic [BYTE_W-1:0] NEWLINE_CODE      = 8'd10;
  localparam logic [BYTE_W-1:0] RETURN_CODE       = 8'd13;
  localparam logic [BYTE_W-1:0] DEFAULT_COLOR_RST = 8'd7;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef struct packed {
    logic idle;
    logic put;
    logic set;
    logic home;
    logic rd_cell;
    logic wr_cell;
    logic sweep_start;
    logic sweep_run;
    logic rsp_load;
  } cmd_t;

  typedef struct packed {
    logic req_fire;
    req_e req_type;
    logic need_scroll;
    logic printable;
    logic sweep_done;
    logic rsp_free;
  } status_t;

endpackage

>>> hw/rtl/tccs_req_if.sv
interface tccs_req_if import tccs_pkg::*; ();
  logic              valid;
  logic              ready;
  req_e              req_type;
  logic [BYTE_W-1:0] char_code;
  logic [BYTE_W-1:0] attribute;
  logic              use_default_color;
  logic [COL_W-1:0]  target_column;
  logic [ROW_W-1:0]  target_row;
  logic [IDX_W-1:0]  cell_index;

  modport source (
    output valid, req_type, char_code, attribute, use_default_color,
           target_column, target_row, cell_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, char_code, attribute, use_default_color,
           target_column, target_row, cell_index,
    output ready
  );
endinterface

>>> hw/rtl/tccs_rsp_if.sv
interface tccs_rsp_if import tccs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  column_now;
  logic [ROW_W-1:0]  row_now;
  logic              did_scroll;
  logic [CELL_W-1:0] cell_value;

  modport source (
    output valid, column_now, row_now, did_scroll, cell_value,
    input  ready
  );
  modport sink (
    input  valid, column_now, row_now, did_scroll, cell_value,
    output ready
  );
endinterface

>>> hw/rtl/tccs_ram.sv
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/tccs_ctrl.sv
module tccs_ctrl import tccs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep_run = 1'b1;
        if (status_i.sweep_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.idle = 1'b1;
        if (status_i.req_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (status_i.req_type)
          REQ_PUT: begin
            cmd_o.put = 1'b1;
            if (status_i.need_scroll) begin
              cmd_o.sweep_start = 1'b1;
              state_d = S_SCROLL;
            end else if (status_i.printable) begin
              state_d = S_WRITE;
            end else begin
              state_d = S_RESP;
            end
          end
          REQ_SET: begin
            cmd_o.set = 1'b1;
            state_d   = S_RESP;
          end
          REQ_CLEAR: begin
            cmd_o.home        = 1'b1;
            cmd_o.sweep_start = 1'b1;
            state_d           = S_CLEAR;
          end
          REQ_READ: begin
            cmd_o.rd_cell = 1'b1;
            state_d       = S_RESP;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_SCROLL: begin
        cmd_o.sweep_run = 1'b1;
        if (status_i.sweep_done) begin
          state_d = status_i.printable ? S_WRITE : S_RESP;
        end
      end
      S_WRITE: begin
        cmd_o.wr_cell = 1'b1;
        state_d       = S_RESP;
      end
      S_CLEAR: begin
        cmd_o.sweep_run = 1'b1;
        if (status_i.sweep_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (status_i.rsp_free) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/tccs_dp.sv
module tccs_dp import tccs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BYTE_W-1:0] cfg_wdata_i,
  tccs_req_if.sink          req,
  tccs_rsp_if.source        rsp,
  input  cmd_t              cmd_i,
  output status_t           status_o
);

  localparam logic [COL_W-1:0]   COLS_C  = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0]   LAST_R  = ROW_W'(ROWS - 1);
  localparam logic [ROW_W:0]     ROWS_R  = (ROW_W + 1)'(ROWS);
  localparam logic [CELL_AW-1:0] COLS_A  = CELL_AW'(COLUMNS);
  localparam logic [CNT_W-1:0]   CELLS_N = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0]   COPY_N  = CNT_W'(COPY_CELLS);
  localparam logic [CNT_W-1:0]   COLS_N  = CNT_W'(COLUMNS);

  logic [BYTE_W-1:0] color_q;
  req_e              type_q;
  logic [BYTE_W-1:0] code_q, attr_q;
  logic [COL_W-1:0]  tcol_q;
  logic [ROW_W-1:0]  trow_q;
  logic [IDX_W-1:0]  idx_q;

  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic              scroll_q;

  logic [CNT_W-1:0]  cnt_q;
  logic              copy_q;

  logic              rsp_valid_q;
  logic [COL_W-1:0]  rsp_col_q;
  logic [ROW_W-1:0]  rsp_row_q;
  logic              rsp_scroll_q;
  logic [CELL_W-1:0] rsp_cell_q;

  logic              req_fire;
  logic              is_nl, is_cr, wrap, need_scroll;
  logic [COL_W-1:0]  col_a, col_b, col_c;
  logic [ROW_W:0]    row_a, row_b;
  logic [ROW_W-1:0]  row_c;
  logic [CELL_AW-1:0] cur_addr;
  logic              idx_ok;

  logic              sweep_done, sw_wr, sw_rd, sw_from_ram;
  logic [CNT_W-1:0]  cnt_m1, cnt_rd;

  logic              ram_we, ram_re;
  logic [CELL_AW-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  assign req.ready = cmd_i.idle;
  assign req_fire  = req.valid && req.ready;

  always_comb begin
    is_nl       = code_q == NEWLINE_CODE;
    is_cr       = code_q == RETURN_CODE;
    row_a       = {1'b0, row_q} + (ROW_W + 1)'(is_nl);
    col_a       = (is_nl || is_cr) ? '0 : col_q;
    wrap        = col_a >= COLS_C;
    col_b       = wrap ? '0 : col_a;
    row_b       = row_a + (ROW_W + 1)'(wrap);
    need_scroll = row_b >= ROWS_R;
    row_c       = need_scroll ? LAST_R : row_b[ROW_W-1:0];
    col_c       = need_scroll ? '0 : col_b;
  end

  assign cur_addr = CELL_AW'(row_q) * COLS_A + CELL_AW'(col_q);
  assign idx_ok   = idx_q < IDX_W'(CELLS);

  assign sweep_done  = cnt_q == CELLS_N;
  assign cnt_m1      = cnt_q - 1'b1;
  assign cnt_rd      = cnt_q + COLS_N;
  assign sw_wr       = cmd_i.sweep_run && (cnt_q != '0);
  assign sw_rd       = cmd_i.sweep_run && copy_q && (cnt_q < COPY_N);
  assign sw_from_ram = copy_q && (cnt_m1 < COPY_N);

  assign ram_we    = sw_wr || cmd_i.wr_cell;
  assign ram_waddr = cmd_i.wr_cell ? cur_addr : cnt_m1[CELL_AW-1:0];
  assign ram_wdata = cmd_i.wr_cell ? {attr_q, code_q}
                                   : (sw_from_ram ? ram_rdata : '0);
  assign ram_re    = sw_rd || (cmd_i.rd_cell && idx_ok);
  assign ram_raddr = cmd_i.rd_cell ? idx_q[CELL_AW-1:0] : cnt_rd[CELL_AW-1:0];

  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= DEFAULT_COLOR_RST;
    end else if (cfg_we_i) begin
      color_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      type_q <= req.req_type;
      code_q <= req.char_code;
      attr_q <= req.use_default_color ? color_q : req.attribute;
      tcol_q <= req.target_column;
      trow_q <= req.target_row;
      idx_q  <= req.cell_index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      scroll_q <= 1'b0;
    end else begin
      if (req_fire) begin
        scroll_q <= 1'b0;
      end
      if (cmd_i.put) begin
        col_q    <= col_c;
        row_q    <= row_c;
        scroll_q <= need_scroll;
      end
      if (cmd_i.set) begin
        col_q <= (tcol_q > COLS_C) ? COLS_C : tcol_q;
        row_q <= (trow_q > LAST_R) ? LAST_R : trow_q;
      end
      if (cmd_i.home) begin
        col_q <= '0;
        row_q <= '0;
      end
      if (cmd_i.wr_cell) begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      copy_q <= 1'b0;
    end else if (cmd_i.sweep_start) begin
      cnt_q  <= '0;
      copy_q <= cmd_i.put;
    end else if (cmd_i.sweep_run && !sweep_done) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_load) begin
      rsp_col_q    <= col_q;
      rsp_row_q    <= row_q;
      rsp_scroll_q <= scroll_q;
      rsp_cell_q   <= (type_q == REQ_READ && idx_ok) ? ram_rdata : '0;
    end
  end

  assign rsp.valid      = rsp_valid_q;
  assign rsp.column_now = rsp_col_q;
  assign rsp.row_now    = rsp_row_q;
  assign rsp.did_scroll = rsp_scroll_q;
  assign rsp.cell_value = rsp_cell_q;

  always_comb begin
    status_o             = '0;
    status_o.req_fire    = req_fire;
    status_o.req_type    = type_q;
    status_o.need_scroll = need_scroll;
    status_o.printable   = !(is_nl || is_cr);
    status_o.sweep_done  = sweep_done;
    status_o.rsp_free    = !rsp_valid_q || rsp.ready;
  end

endmodule

>>> hw/rtl/text_console_cursor_scroll_unit.sv
// Text console: 25 x 80 screen of 16-bit cells (attribute high byte,
// character low byte) with a cursor.
// req_i takes one request per transfer: put character, set cursor,
// clear screen or read cell. rsp_o returns exactly one result per request:
// cursor after the request, scroll flag, and the cell for a read.
// cfg_we_i/cfg_wdata_i write the default color; write only while idle.
// Steps per request, from acceptance to the result register:
//   set cursor, read cell, newline, carriage return: result only
//   printable character without scroll: cell write, then result
//   any put that scrolls: full screen copy through the single-port-pair
//   screen RAM, one cell per cycle, then cell write if printable, result
//   clear screen: one cell per cycle zeroing sweep, then result
// Requests are taken one at a time; the next one is accepted while a
// result still waits in the output register.
// After reset the screen RAM is zeroed by a sweep during which req_i
// is not ready. A stalled rsp_o holds its result; the block then
// finishes at most one further request and waits.
module text_console_cursor_scroll_unit import tccs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BYTE_W-1:0] cfg_wdata_i,
  tccs_req_if.sink          req_i,
  tccs_rsp_if.source        rsp_o
);

  cmd_t    cmd;
  status_t status;

  tccs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tccs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_i),
    .rsp         (rsp_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |-> !cmd.sweep_run)
    else $error("request accepted during screen sweep");

  a_no_cell_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_cell |-> !cmd.sweep_run)
    else $error("cell write collides with sweep");

  a_rsp_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rsp_load |-> (!rsp_o.valid || rsp_o.ready))
    else $error("result overwrites a pending result");

  a_single_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.idle, cmd.put, cmd.set, cmd.rd_cell, cmd.wr_cell, cmd.rsp_load}))
    else $error("conflicting datapath commands");

endmodule

>>> tb/sv/text_console_cursor_scroll_unit_tb.sv
`timescale 1ns / 100ps

module text_console_cursor_scroll_unit_tb;
  import tccs_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RANDOM_ITEMS = 1130;
  localparam int SWEEP_BUDGET = 100;
  localparam int SETTLE       = 12;

  typedef struct packed {
    req_e              kind;
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] attr;
    logic              use_default;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [IDX_W-1:0]  index;
  } console_req_t;

  typedef struct packed {
    logic [COL_W-1:0]  column_now;
    logic [ROW_W-1:0]  row_now;
    logic              scrolled;
    logic [CELL_W-1:0] cell_word;
  } console_rsp_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;

  tccs_req_if req_bus ();
  tccs_rsp_if rsp_bus ();

  text_console_cursor_scroll_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  // shadow of the console
  logic [CELL_W-1:0] shadow_screen [CELLS];
  int                shadow_col;
  int                shadow_row;
  logic [BYTE_W-1:0] shadow_color;
  int                last_written;

  console_rsp_t pending_results [$];
  int           error_count;
  int           sweep_count;
  int           random_sent;
  bit           quiet_mode;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic bit sweeps_ahead(input console_req_t rq);
    int c;
    int r;
    if (rq.kind == REQ_CLEAR) return 1'b1;
    if (rq.kind != REQ_PUT) return 1'b0;
    c = shadow_col;
    r = shadow_row;
    if (rq.code == NEWLINE_CODE) begin
      r++;
      c = 0;
    end
    if (rq.code == RETURN_CODE) c = 0;
    if (c >= COLUMNS) r++;
    return r >= ROWS;
  endfunction

  task automatic scroll_shadow();
    for (int i = 0; i < COPY_CELLS; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
    for (int i = COPY_CELLS; i < CELLS; i++) shadow_screen[i] = '0;
  endtask

  task automatic advance_console(input console_req_t rq, output console_rsp_t rs);
    logic [BYTE_W-1:0] color;
    bit                ctrl;
    rs = '0;
    case (rq.kind)
      REQ_PUT: begin
        color = rq.use_default ? shadow_color : rq.attr;
        ctrl  = (rq.code == NEWLINE_CODE) || (rq.code == RETURN_CODE);
        if (rq.code == NEWLINE_CODE) begin
          shadow_row++;
          shadow_col = 0;
        end
        if (rq.code == RETURN_CODE) shadow_col = 0;
        if (shadow_col >= COLUMNS) begin
          shadow_col = 0;
          shadow_row++;
        end
        if (shadow_row >= ROWS) begin
          shadow_row = ROWS - 1;
          shadow_col = 0;
          scroll_shadow();
          rs.scrolled = 1'b1;
          sweep_count++;
        end
        if (!ctrl) begin
          last_written = shadow_row * COLUMNS + shadow_col;
          shadow_screen[last_written] = {color, rq.code};
          shadow_col++;
        end
      end
      REQ_SET: begin
        shadow_col = (rq.col > COLUMNS) ? COLUMNS : int'(rq.col);
        shadow_row = (rq.row > ROWS - 1) ? ROWS - 1 : int'(rq.row);
      end
      REQ_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_screen[i] = '0;
        shadow_col = 0;
        shadow_row = 0;
        sweep_count++;
      end
      default: begin
        if (rq.index < CELLS) rs.cell_word = shadow_screen[rq.index];
      end
    endcase
    rs.column_now = COL_W'(shadow_col);
    rs.row_now    = ROW_W'(shadow_row);
  endtask

  task automatic sender_idle(input int n);
    repeat (n) begin
      @(negedge clk_i);
      req_bus.valid = 1'b0;
    end
  endtask

  task automatic send_request(input console_req_t rq);
    console_rsp_t rs;
    if (!quiet_mode && $urandom_range(0, 7) == 0) sender_idle($urandom_range(1, 6));
    @(negedge clk_i);
    req_bus.valid             = 1'b1;
    req_bus.req_type          = rq.kind;
    req_bus.char_code         = rq.code;
    req_bus.attribute         = rq.attr;
    req_bus.use_default_color = rq.use_default;
    req_bus.target_column     = rq.col;
    req_bus.target_row        = rq.row;
    req_bus.cell_index        = rq.index;
    do @(posedge clk_i); while (!req_bus.ready);
    advance_console(rq, rs);
    pending_results.push_back(rs);
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    req_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_default_color(input logic [BYTE_W-1:0] value);
    wait_drain();
    repeat (SETTLE) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we       = 1'b0;
    shadow_color = value;
  endtask

  function automatic console_req_t make_put(input logic [BYTE_W-1:0] code,
                                            input logic [BYTE_W-1:0] attr,
                                            input logic use_default);
    console_req_t rq;
    rq             = '0;
    rq.kind        = REQ_PUT;
    rq.code        = code;
    rq.attr        = attr;
    rq.use_default = use_default;
    return rq;
  endfunction

  function automatic console_req_t make_set(input int col, input int row);
    console_req_t rq;
    rq      = '0;
    rq.kind = REQ_SET;
    rq.col  = COL_W'(col);
    rq.row  = ROW_W'(row);
    return rq;
  endfunction

  function automatic console_req_t make_read(input int index);
    console_req_t rq;
    rq       = '0;
    rq.kind  = REQ_READ;
    rq.index = IDX_W'(index);
    return rq;
  endfunction

  function automatic console_req_t make_clear();
    console_req_t rq;
    rq      = '0;
    rq.kind = REQ_CLEAR;
    return rq;
  endfunction

  // mostly text printing with local reads; set cursor leans to the bottom edge
  function automatic console_req_t pick_random_request();
    console_req_t rq;
    int           roll;
    int           pick;
    rq.kind        = req_e'($urandom_range(0, 3));
    rq.code        = BYTE_W'($urandom_range(0, 255));
    rq.attr        = BYTE_W'($urandom_range(0, 255));
    rq.use_default = 1'($urandom_range(0, 1));
    rq.col         = COL_W'($urandom_range(0, 127));
    rq.row         = ROW_W'($urandom_range(0, 31));
    rq.index       = IDX_W'($urandom_range(0, 2047));
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 19);
    if (roll < 55) begin
      rq.kind = REQ_PUT;
      if (pick < 2) rq.code = NEWLINE_CODE;
      else if (pick == 2) rq.code = RETURN_CODE;
    end else if (roll < 67) begin
      rq.kind = REQ_SET;
      if (pick < 5) begin
        rq.row = ROW_W'($urandom_range(ROWS - 1, 31));
        rq.col = COL_W'($urandom_range(60, 127));
      end else if (pick < 10) begin
        rq.row = ROW_W'(ROWS - 1);
        rq.col = COL_W'($urandom_range(COLUMNS - 10, COLUMNS));
      end else if (pick < 16) begin
        rq.row = ROW_W'($urandom_range(0, ROWS - 1));
        rq.col = COL_W'($urandom_range(0, COLUMNS));
      end
    end else if (roll < 69) begin
      rq.kind = REQ_CLEAR;
    end else begin
      rq.kind = REQ_READ;
      if (pick < 5) rq.index = IDX_W'(shadow_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
      else if (pick < 9) rq.index = IDX_W'(COPY_CELLS - COLUMNS + $urandom_range(0, 2 * COLUMNS - 1));
      else if (pick < 14) rq.index = IDX_W'(last_written);
    end
    return rq;
  endfunction

  // receive side: random stall bursts, check each transfer against the shadow
  initial begin
    console_rsp_t exp;
    int           stall_left;
    stall_left    = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with no request outstanding");
        end else begin
          exp = pending_results.pop_front();
          if (rsp_bus.column_now !== exp.column_now)
            report_mismatch($sformatf("column_now %0d, want %0d",
                                      rsp_bus.column_now, exp.column_now));
          if (rsp_bus.row_now !== exp.row_now)
            report_mismatch($sformatf("row_now %0d, want %0d", rsp_bus.row_now, exp.row_now));
          if (rsp_bus.did_scroll !== exp.scrolled)
            report_mismatch($sformatf("did_scroll %0b, want %0b",
                                      rsp_bus.did_scroll, exp.scrolled));
          if (rsp_bus.cell_value !== exp.cell_word)
            report_mismatch($sformatf("cell_value %h, want %h",
                                      rsp_bus.cell_value, exp.cell_word));
        end
      end
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready = 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
        stall_left    = $urandom_range(0, 5);
        rsp_bus.ready = 1'b0;
      end else begin
        rsp_bus.ready = 1'b1;
      end
    end
  end

  task automatic test_reset_state();
    send_request(make_read(0));
  endtask

  task automatic test_put_character();
    program_default_color(8'h5A);
    send_request(make_put(8'h41, 8'hFF, 1'b0));
    send_request(make_put(8'h00, 8'h00, 1'b1));
    send_request(make_put(8'hFF, 8'h00, 1'b0));
    send_request(make_read(0));
    send_request(make_read(1));
    send_request(make_read(2));
  endtask

  task automatic test_control_codes();
    send_request(make_set(5, 3));
    send_request(make_put(NEWLINE_CODE, 8'h1F, 1'b0));
    send_request(make_set(9, 4));
    send_request(make_put(RETURN_CODE, 8'h1F, 1'b0));
  endtask

  task automatic test_line_wrap();
    send_request(make_set(COLUMNS - 1, 2));
    send_request(make_put(8'h78, 8'h2E, 1'b0));
    send_request(make_put(8'h79, 8'hD1, 1'b0));
    send_request(make_read(2 * COLUMNS + COLUMNS - 1));
    send_request(make_read(3 * COLUMNS));
  endtask

  task automatic test_saturate_and_scroll();
    send_request(make_set(127, 31));
    send_request(make_put(8'h7A, 8'h00, 1'b1));
    send_request(make_read((ROWS - 1) * COLUMNS));
    send_request(make_put(NEWLINE_CODE, 8'h00, 1'b0));
    send_request(make_read((ROWS - 2) * COLUMNS));
  endtask

  task automatic test_clear_and_range();
    send_request(make_clear());
    send_request(make_read(0));
    send_request(make_read(CELLS));
    send_request(make_read(2047));
  endtask

  task automatic test_random_traffic(input int count);
    console_req_t rq;
    int           cap;
    repeat (count) begin
      rq  = pick_random_request();
      cap = 4 + random_sent * SWEEP_BUDGET / RANDOM_ITEMS;
      if (sweeps_ahead(rq) && sweep_count >= cap)
        rq = make_set($urandom_range(0, COLUMNS), $urandom_range(0, ROWS - 2));
      send_request(rq);
      random_sent++;
    end
  endtask

  task automatic test_sender_pause();
    test_random_traffic(20);
    wait_drain();
    test_random_traffic(20);
  endtask

  initial begin
    rst_ni                    = 1'b0;
    cfg_we                    = 1'b0;
    cfg_wdata                 = '0;
    req_bus.valid             = 1'b0;
    req_bus.req_type          = REQ_PUT;
    req_bus.char_code         = '0;
    req_bus.attribute         = '0;
    req_bus.use_default_color = 1'b0;
    req_bus.target_column     = '0;
    req_bus.target_row        = '0;
    req_bus.cell_index        = '0;
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = '0;
    shadow_col   = 0;
    shadow_row   = 0;
    shadow_color = DEFAULT_COLOR_RST;
    last_written = 0;
    error_count  = 0;
    sweep_count  = 0;
    random_sent  = 0;
    quiet_mode   = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_put_character();
    test_control_codes();
    test_line_wrap();
    test_saturate_and_scroll();
    test_clear_and_range();

    program_default_color(8'h00);
    test_random_traffic(300);
    program_default_color(8'hFF);
    test_random_traffic(300);
    test_sender_pause();
    program_default_color(BYTE_W'($urandom_range(0, 255)));
    test_random_traffic(300);
    program_default_color(DEFAULT_COLOR_RST);
    quiet_mode = 1'b1;
    test_random_traffic(190);

    wait_drain();
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> text_console_cursor_scroll_unit.f
hw/rtl/tccs_pkg.sv
hw/rtl/tccs_req_if.sv
hw/rtl/tccs_rsp_if.sv
hw/rtl/tccs_ram.sv
hw/rtl/tccs_ctrl.sv
hw/rtl/tccs_dp.sv
hw/rtl/text_console_cursor_scroll_unit.sv
tb/sv/text_console_cursor_scroll_unit_tb.sv
